// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define GTLM_ASSERT_NOW(lbl, clk, rst, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, gated off during reset.
`define GTLM_ASSERT_NXT(lbl, clk, rst, ant, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gtlm_pkg.sv =====
// Shared constants, types and tables for the GPS to map projection pipeline.
`timescale 1ns / 1ps
package gtlm_pkg;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int NLANE = 2;
  localparam int ANG_W = 32;
  localparam int XY_W  = 33;
  localparam int Z_W   = 34;
  localparam int SQRT_STEPS = 32;
  localparam int DIV_Q_W = 34;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic signed [XY_W-1:0] K_Q30 = 33'sd652032874;
  localparam logic [30:0] E_Q30 = 31'd1080978303;
  localparam logic [63:0] A_MM  = 64'd6378137000;
  localparam logic [63:0] A_Q30 = A_MM << 30;
  localparam logic [30:0] P_Q60 = 31'd2012227627;
  // floor(2^64 / 3.6e9): turns 1e-7 degree into binary angle
  localparam logic [32:0] RECIP_TURN = 33'd5124095576;
  localparam logic [34:0] TURN_DEG7      = 35'd3600000000;
  localparam logic [34:0] HALF_TURN_DEG7 = 35'd1800000000;
  localparam logic [34:0] TWO_TURN_DEG7  = 35'd7200000000;

  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_LAT = 2'd0,
    REG_ORIGIN_LON = 2'd1,
    REG_MAP_ROT    = 2'd2
  } cfg_reg_t;

  // arctangent of 2^-i in binary angle units (one turn = 2^32)
  function automatic logic [31:0] atan_entry(input int i);
    case (i)
      0:  return 32'h2000_0000;
      1:  return 32'h12E4_051E;
      2:  return 32'h09FB_385B;
      3:  return 32'h0511_11D4;
      4:  return 32'h028B_0D43;
      5:  return 32'h0145_D7E1;
      6:  return 32'h00A2_F61E;
      7:  return 32'h0051_7C55;
      8:  return 32'h0028_BE53;
      9:  return 32'h0014_5F2F;
      10: return 32'h000A_2F98;
      11: return 32'h0005_17CC;
      12: return 32'h0002_8BE6;
      13: return 32'h0001_45F3;
      14: return 32'h0000_A2FA;
      15: return 32'h0000_517D;
      16: return 32'h0000_28BE;
      17: return 32'h0000_145F;
      18: return 32'h0000_0A30;
      19: return 32'h0000_0518;
      20: return 32'h0000_028C;
      21: return 32'h0000_0146;
      22: return 32'h0000_00A3;
      23: return 32'h0000_0051;
      24: return 32'h0000_0029;
      25: return 32'h0000_0014;
      26: return 32'h0000_000A;
      27: return 32'h0000_0005;
      28: return 32'h0000_0003;
      29: return 32'h0000_0001;
      30: return 32'h0000_0001;
      default: return 32'h0000_0000;
    endcase
  endfunction

endpackage

// ===== rtl/gtlm_intf.sv =====
// Handshake channel interfaces: GPS fix in, map point out, register writes.
`timescale 1ns / 1ps
interface gtlm_fix_if;
  logic               valid;
  logic               ready;
  logic               has_fix;
  logic signed [30:0] latitude_in;
  logic signed [31:0] longitude_in;
  modport source (output valid, has_fix, latitude_in, longitude_in, input ready);
  modport sink (input valid, has_fix, latitude_in, longitude_in, output ready);
endinterface

interface gtlm_map_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] map_x_mm;
  logic signed [31:0] map_y_mm;
  logic               saturated;
  modport source (output valid, map_x_mm, map_y_mm, saturated, input ready);
  modport sink (input valid, map_x_mm, map_y_mm, saturated, output ready);
endinterface

interface gtlm_cfg_if import gtlm_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/gtlm_cordic.sv =====
// Pipelined two-lane rotation-mode CORDIC giving cos and sin in Q30.
`timescale 1ns / 1ps
module gtlm_cordic import gtlm_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  pipe_ctl_t              ctl,
  input  logic [ANG_W-1:0]       ang [NLANE],
  input  logic [SIDE_W-1:0]      side_in,
  output logic                   vld_out,
  output logic signed [XY_W-1:0] cos_out [NLANE],
  output logic signed [XY_W-1:0] sin_out [NLANE],
  output logic [SIDE_W-1:0]      side_out
);

  localparam int NS = (STAGES > 32) ? 32 : STAGES;

  logic                   vld  [NS+1];
  logic [SIDE_W-1:0]      side [NS+1];
  logic signed [XY_W-1:0] x    [NS+1][NLANE];
  logic signed [XY_W-1:0] y    [NS+1][NLANE];
  logic signed [Z_W-1:0]  z    [NS+1][NLANE];
  logic                   flip [NS+1][NLANE];

  logic                   pre_flip [NLANE];
  logic signed [Z_W-1:0]  pre_z    [NLANE];
  logic [ANG_W-1:0]       ang_q    [NLANE];
  logic [ANG_W-1:0]       ang_r    [NLANE];

  // fold the left half plane onto the right one, undone at the end
  always_comb begin
    for (int l = 0; l < NLANE; l++) begin
      ang_q[l]    = ang[l] + 32'h4000_0000;
      pre_flip[l] = ang_q[l][ANG_W-1];
      ang_r[l]    = pre_flip[l] ? ang[l] + 32'h8000_0000 : ang[l];
      pre_z[l]    = Z_W'($signed(ang_r[l]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= NS; k++) vld[k] <= 1'b0;
      vld_out <= 1'b0;
    end else if (ctl.en) begin
      vld[0] <= ctl.vld;
      for (int k = 0; k < NS; k++) vld[k+1] <= vld[k];
      vld_out <= vld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      side[0] <= side_in;
      for (int l = 0; l < NLANE; l++) begin
        x[0][l]    <= K_Q30;
        y[0][l]    <= '0;
        z[0][l]    <= pre_z[l];
        flip[0][l] <= pre_flip[l];
      end
      for (int k = 0; k < NS; k++) begin
        side[k+1] <= side[k];
        for (int l = 0; l < NLANE; l++) begin
          flip[k+1][l] <= flip[k][l];
          if (!z[k][l][Z_W-1]) begin
            x[k+1][l] <= x[k][l] - (y[k][l] >>> k);
            y[k+1][l] <= y[k][l] + (x[k][l] >>> k);
            z[k+1][l] <= z[k][l] - $signed(Z_W'(atan_entry(k)));
          end else begin
            x[k+1][l] <= x[k][l] + (y[k][l] >>> k);
            y[k+1][l] <= y[k][l] - (x[k][l] >>> k);
            z[k+1][l] <= z[k][l] + $signed(Z_W'(atan_entry(k)));
          end
        end
      end
      side_out <= side[NS];
      for (int l = 0; l < NLANE; l++) begin
        cos_out[l] <= flip[NS][l] ? -x[NS][l] : x[NS][l];
        sin_out[l] <= flip[NS][l] ? -y[NS][l] : y[NS][l];
      end
    end
  end

endmodule

// ===== rtl/gtlm_isqrt.sv =====
// Pipelined 64-bit integer square root, two radicand bits per stage.
`timescale 1ns / 1ps
module gtlm_isqrt import gtlm_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  pipe_ctl_t         ctl,
  input  logic [63:0]       rad,
  input  logic [SIDE_W-1:0] side_in,
  output logic              vld_out,
  output logic [31:0]       root,
  output logic [SIDE_W-1:0] side_out
);

  logic              vld  [SQRT_STEPS+1];
  logic [SIDE_W-1:0] side [SQRT_STEPS+1];
  logic [63:0]       v    [SQRT_STEPS+1];
  logic [63:0]       r    [SQRT_STEPS+1];
  logic [63:0]       trial [SQRT_STEPS];
  logic              take  [SQRT_STEPS];

  always_comb begin
    for (int k = 0; k < SQRT_STEPS; k++) begin
      trial[k] = r[k] + (64'd1 << (62 - 2 * k));
      take[k]  = v[k] >= trial[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= SQRT_STEPS; k++) vld[k] <= 1'b0;
    end else if (ctl.en) begin
      vld[0] <= ctl.vld;
      for (int k = 0; k < SQRT_STEPS; k++) vld[k+1] <= vld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      side[0] <= side_in;
      v[0]    <= rad;
      r[0]    <= '0;
      for (int k = 0; k < SQRT_STEPS; k++) begin
        side[k+1] <= side[k];
        if (take[k]) begin
          v[k+1] <= v[k] - trial[k];
          r[k+1] <= (r[k] >> 1) + (64'd1 << (62 - 2 * k));
        end else begin
          v[k+1] <= v[k];
          r[k+1] <= r[k] >> 1;
        end
      end
    end
  end

  assign vld_out  = vld[SQRT_STEPS];
  assign root     = r[SQRT_STEPS][31:0];
  assign side_out = side[SQRT_STEPS];

endmodule

// ===== rtl/gtlm_div.sv =====
// Pipelined restoring divider: rounded equatorial radius over the root, one bit a stage.
`timescale 1ns / 1ps
module gtlm_div import gtlm_pkg::*; #(
  parameter int SIDE_W = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  pipe_ctl_t          ctl,
  input  logic [31:0]        den,
  input  logic [SIDE_W-1:0]  side_in,
  output logic               vld_out,
  output logic [DIV_Q_W-1:0] quo,
  output logic [SIDE_W-1:0]  side_out
);

  logic               vld  [DIV_Q_W+1];
  logic [SIDE_W-1:0]  side [DIV_Q_W+1];
  logic [63:0]        rem  [DIV_Q_W+1];
  logic [31:0]        d    [DIV_Q_W+1];
  logic [DIV_Q_W-1:0] q    [DIV_Q_W+1];
  logic [65:0]        dsh  [DIV_Q_W];
  logic               take [DIV_Q_W];
  logic [31:0]        den_nz;

  // a zero root is treated as one
  assign den_nz = (den == '0) ? 32'd1 : den;

  always_comb begin
    for (int k = 0; k < DIV_Q_W; k++) begin
      dsh[k]  = 66'(d[k]) << (DIV_Q_W - 1 - k);
      take[k] = {2'b00, rem[k]} >= dsh[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= DIV_Q_W; k++) vld[k] <= 1'b0;
    end else if (ctl.en) begin
      vld[0] <= ctl.vld;
      for (int k = 0; k < DIV_Q_W; k++) vld[k+1] <= vld[k];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      side[0] <= side_in;
      d[0]    <= den_nz;
      rem[0]  <= A_Q30 + 64'(den_nz >> 1);
      q[0]    <= '0;
      for (int k = 0; k < DIV_Q_W; k++) begin
        side[k+1] <= side[k];
        d[k+1]    <= d[k];
        if (take[k]) begin
          rem[k+1] <= rem[k] - dsh[k][63:0];
          q[k+1]   <= q[k] | (DIV_Q_W'(1) << (DIV_Q_W - 1 - k));
        end else begin
          rem[k+1] <= rem[k];
          q[k+1]   <= q[k];
        end
      end
    end
  end

  assign vld_out  = vld[DIV_Q_W];
  assign quo      = q[DIV_Q_W];
  assign side_out = side[DIV_Q_W];

endmodule

// ===== rtl/gps_to_local_map_projection.sv =====
// Top level: GPS fix to rotated local map coordinates in millimetres.
//
//  channel  dir  payload                                  accepted when
//  gps      in   has_fix, latitude_in, longitude_in       gps.valid & gps.ready
//  map      out  map_x_mm, map_y_mm, saturated            map.valid & map.ready
//  cfg      in   index, data (origin lat/lon, rotation)   cfg.valid & cfg.ready
//
// One item a cycle sustained while map is ready; the pipeline depth is set
// mostly by the 32-stage root and 34-stage divider.
// rst is synchronous; it clears all valid bits and the three registers.
// A stall on map freezes the whole pipeline in place; gps.ready is low only
// while a finished item waits on map. Items without a fix leave no result.
`timescale 1ns / 1ps
module gps_to_local_map_projection import gtlm_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  gtlm_fix_if.sink   gps,
  gtlm_map_if.source map,
  gtlm_cfg_if.sink   cfg
);

  typedef struct packed {
    logic signed [30:0] lat;
    logic signed [31:0] lon;
  } fix_side_t;

  typedef struct packed {
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic signed [32:0] c;
    logic signed [29:0] crq;
    logic signed [29:0] srq;
  } geo_side_t;

  // configuration registers
  logic signed [30:0] origin_latitude;
  logic signed [31:0] origin_longitude;
  logic [23:0]        map_rotation;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_latitude  <= '0;
      origin_longitude <= '0;
      map_rotation     <= '0;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_ORIGIN_LAT: origin_latitude  <= cfg.data[30:0];
        REG_ORIGIN_LON: origin_longitude <= cfg.data;
        REG_MAP_ROT:    map_rotation     <= cfg.data[23:0];
        default: ;
      endcase
    end
  end

  // global advance: the output register is free or being drained
  logic adv;
  logic o_vld;
  assign adv       = !o_vld || map.ready;
  assign gps.ready = adv;

  // ---- latitude to binary angle: reciprocal multiply, then remainder fix
  logic [30:0] a_mag;
  logic [63:0] a_prod;
  assign a_mag  = gps.latitude_in[30] ? 31'(-gps.latitude_in) : 31'(gps.latitude_in);
  assign a_prod = {33'd0, a_mag} * {31'd0, RECIP_TURN};

  logic               a1_vld, a2_vld, a3_vld;
  logic [30:0]        a1_q0, a1_mag, a2_q0;
  logic               a1_neg, a2_neg;
  logic [34:0]        a2_rem;
  fix_side_t          a1_side, a2_side, a3_side;
  logic [ANG_W-1:0]   a3_ang;
  logic [65:0]        a1_mfull;
  logic [31:0]        a2_ang_u;
  assign a1_mfull = {35'd0, a1_q0} * {31'd0, TURN_DEG7};
  // rounded quotient is q0, q0+1 or q0+2
  assign a2_ang_u = {1'b0, a2_q0} + 32'(a2_rem >= TURN_DEG7) + 32'(a2_rem >= TWO_TURN_DEG7);

  // ---- CORDIC: lane 0 latitude, lane 1 map rotation
  logic [ANG_W-1:0]       cor_ang [NLANE];
  logic signed [XY_W-1:0] cor_c   [NLANE];
  logic signed [XY_W-1:0] cor_s   [NLANE];
  logic                   cor_vld;
  fix_side_t              cor_side;
  pipe_ctl_t              cor_ctl;
  logic [$bits(fix_side_t)-1:0] cor_side_in;

  assign cor_ang[0] = a3_ang;
  assign cor_ang[1] = {map_rotation, 8'd0};
  assign cor_ctl    = '{en: adv, vld: a3_vld};
  assign cor_side_in = a3_side;

  gtlm_cordic #(
    .STAGES (CORDIC_STAGES),
    .SIDE_W ($bits(fix_side_t))
  ) u_cordic (
    .clk      (clk),
    .rst      (rst),
    .ctl      (cor_ctl),
    .ang      (cor_ang),
    .side_in  (cor_side_in),
    .vld_out  (cor_vld),
    .cos_out  (cor_c),
    .sin_out  (cor_s),
    .side_out (cor_side)
  );

  // ---- radius denominator D = c^2 + E*floor(s^2 / 2^30)
  logic signed [65:0] m_cc, m_ss;
  logic signed [32:0] m_crt, m_srt;
  assign m_cc  = cor_c[0] * cor_c[0];
  assign m_ss  = cor_s[0] * cor_s[0];
  assign m_crt = cor_c[1] + 33'sd8;
  assign m_srt = cor_s[1] + 33'sd8;

  logic        m1_vld, m2_vld, m3_vld;
  logic [63:0] m1_cc, m1_ss, m2_cc, m2_es, m3_d;
  geo_side_t   m1_side, m2_side, m3_side;
  logic [64:0] m_es;
  assign m_es = {31'd0, m1_ss[63:30]} * {34'd0, E_Q30};

  // ---- square root and divider
  pipe_ctl_t   sq_ctl, dv_ctl;
  logic        sq_vld, dv_vld;
  logic [31:0] sq_root;
  logic [$bits(geo_side_t)-1:0] sq_side, dv_side;
  logic [DIV_Q_W-1:0] dv_r;

  assign sq_ctl = '{en: adv, vld: m3_vld};
  assign dv_ctl = '{en: adv, vld: sq_vld};

  gtlm_isqrt #(
    .SIDE_W ($bits(geo_side_t))
  ) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .ctl      (sq_ctl),
    .rad      (m3_d),
    .side_in  (m3_side),
    .vld_out  (sq_vld),
    .root     (sq_root),
    .side_out (sq_side)
  );

  gtlm_div #(
    .SIDE_W ($bits(geo_side_t))
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (dv_ctl),
    .den      (sq_root),
    .side_in  (sq_side),
    .vld_out  (dv_vld),
    .quo      (dv_r),
    .side_out (dv_side)
  );

  geo_side_t dv_geo;
  assign dv_geo = dv_side;

  // ---- scale: S = round(R*P / 2^36), split multiply
  logic               t1_vld, t2_vld, t3_vld, t4_vld, t5_vld, t6_vld;
  logic [47:0]        t1_ph, t1_pl;
  geo_side_t          t1_side;
  logic [65:0]        t_ssum;
  logic signed [31:0] t_dlat;
  logic signed [32:0] t_dlon;
  assign t_ssum = (66'(t1_ph) << 17) + 66'(t1_pl) + (66'd1 << 35);
  assign t_dlat = 32'(t1_side.lat) - 32'(origin_latitude);
  assign t_dlon = 33'(t1_side.lon) - 33'(origin_longitude);

  logic [29:0]        t2_s;
  logic signed [32:0] t2_c;
  logic signed [31:0] t2_dlat;
  logic signed [32:0] t2_dlon, t3_dlon, t4_dlon;
  logic signed [29:0] t2_crq, t2_srq, t3_crq, t3_srq, t4_crq, t4_srq;
  logic signed [29:0] t5_crq, t5_srq, t6_crq, t6_srq;
  logic signed [63:0] t_sc, t3_sc;
  logic signed [62:0] t_sd, t3_sd;
  assign t_sc = $signed({1'b0, t2_s}) * t2_c;
  assign t_sd = $signed({1'b0, t2_s}) * t2_dlat;

  logic signed [30:0] t4_sx;
  logic signed [39:0] t4_n, t5_n, t6_n, t6_e;
  logic signed [63:0] t_ep, t5_ep;
  assign t_ep = t4_sx * t4_dlon;

  // ---- rotation by the map angle, Q26 cos/sin
  logic               r1_vld, r2_vld;
  logic signed [69:0] r_ecr, r_nsr, r_esr, r_ncr;
  logic signed [69:0] r1_ecr, r1_nsr, r1_esr, r1_ncr;
  logic signed [70:0] r2_xs, r2_ys;
  assign r_ecr = t6_e * t6_crq;
  assign r_nsr = t6_n * t6_srq;
  assign r_esr = t6_e * t6_srq;
  assign r_ncr = t6_n * t6_crq;

  // ---- output rounding and saturation
  logic [44:0] o_xv, o_yv;
  logic        o_xfit, o_yfit;
  assign o_xv   = r2_xs[70:26];
  assign o_yv   = r2_ys[70:26];
  assign o_xfit = o_xv[44:31] == {14{o_xv[31]}};
  assign o_yfit = o_yv[44:31] == {14{o_yv[31]}};

  logic signed [31:0] o_x, o_y;
  logic               o_sat;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a1_vld <= 1'b0; a2_vld <= 1'b0; a3_vld <= 1'b0;
      m1_vld <= 1'b0; m2_vld <= 1'b0; m3_vld <= 1'b0;
      t1_vld <= 1'b0; t2_vld <= 1'b0; t3_vld <= 1'b0;
      t4_vld <= 1'b0; t5_vld <= 1'b0; t6_vld <= 1'b0;
      r1_vld <= 1'b0; r2_vld <= 1'b0; o_vld  <= 1'b0;
    end else if (adv) begin
      a1_vld <= gps.valid && gps.has_fix;
      a2_vld <= a1_vld; a3_vld <= a2_vld;
      m1_vld <= cor_vld; m2_vld <= m1_vld; m3_vld <= m2_vld;
      t1_vld <= dv_vld; t2_vld <= t1_vld; t3_vld <= t2_vld;
      t4_vld <= t3_vld; t5_vld <= t4_vld; t6_vld <= t5_vld;
      r1_vld <= t6_vld; r2_vld <= r1_vld; o_vld  <= r2_vld;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      a1_q0   <= a_prod[62:32];
      a1_mag  <= a_mag;
      a1_neg  <= gps.latitude_in[30];
      a1_side <= '{lat: gps.latitude_in, lon: gps.longitude_in};

      a2_q0   <= a1_q0;
      a2_neg  <= a1_neg;
      a2_rem  <= {a1_mag[2:0], 32'd0} + HALF_TURN_DEG7 - a1_mfull[34:0];
      a2_side <= a1_side;

      a3_ang  <= a2_neg ? -a2_ang_u : a2_ang_u;
      a3_side <= a2_side;

      m1_cc   <= m_cc[63:0];
      m1_ss   <= m_ss[63:0];
      m1_side <= '{lat: cor_side.lat, lon: cor_side.lon, c: cor_c[0],
                   crq: 30'(m_crt >>> 4), srq: 30'(m_srt >>> 4)};

      m2_cc   <= m1_cc;
      m2_es   <= m_es[63:0];
      m2_side <= m1_side;

      m3_d    <= m2_cc + m2_es;
      m3_side <= m2_side;

      t1_ph   <= {31'd0, dv_r[33:17]} * {17'd0, P_Q60};
      t1_pl   <= {31'd0, dv_r[16:0]} * {17'd0, P_Q60};
      t1_side <= dv_geo;

      t2_s    <= t_ssum[65:36];
      t2_c    <= t1_side.c;
      t2_dlat <= t_dlat;
      t2_dlon <= t_dlon;
      t2_crq  <= t1_side.crq;
      t2_srq  <= t1_side.srq;

      t3_sc   <= t_sc;
      t3_sd   <= t_sd;
      t3_dlon <= t2_dlon;
      t3_crq  <= t2_crq;
      t3_srq  <= t2_srq;

      t4_sx   <= 31'((t3_sc + 64'sd536870912) >>> 30);
      t4_n    <= 40'((t3_sd + 63'sd8388608) >>> 24);
      t4_dlon <= t3_dlon;
      t4_crq  <= t3_crq;
      t4_srq  <= t3_srq;

      t5_ep   <= t_ep;
      t5_n    <= t4_n;
      t5_crq  <= t4_crq;
      t5_srq  <= t4_srq;

      t6_e    <= 40'((t5_ep + 64'sd8388608) >>> 24);
      t6_n    <= t5_n;
      t6_crq  <= t5_crq;
      t6_srq  <= t5_srq;

      r1_ecr  <= r_ecr;
      r1_nsr  <= r_nsr;
      r1_esr  <= r_esr;
      r1_ncr  <= r_ncr;

      r2_xs   <= 71'(r1_ecr) - 71'(r1_nsr) + 71'sd33554432;
      r2_ys   <= 71'(r1_esr) + 71'(r1_ncr) + 71'sd33554432;

      o_x     <= o_xfit ? o_xv[31:0] : (o_xv[44] ? 32'h8000_0000 : 32'h7FFF_FFFF);
      o_y     <= o_yfit ? o_yv[31:0] : (o_yv[44] ? 32'h8000_0000 : 32'h7FFF_FFFF);
      o_sat   <= !o_xfit || !o_yfit;
    end
  end

  assign map.valid     = o_vld;
  assign map.map_x_mm  = o_x;
  assign map.map_y_mm  = o_y;
  assign map.saturated = o_sat;

endmodule

// ===== rtl/gtlm_chk.sv =====
// Port-level checker for the projection block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module gtlm_chk (
  input logic        clk,
  input logic        rst,
  gtlm_fix_if.sink   gps,
  gtlm_map_if.source map
);

  `GTLM_ASSERT_NXT(a_out_hold, clk, rst, map.valid && !map.ready, map.valid && $stable(map.map_x_mm) && $stable(map.map_y_mm) && $stable(map.saturated), "map item changed under stall")
  `GTLM_ASSERT_NOW(a_in_stall, clk, rst, !gps.ready, map.valid && !map.ready, "gps stalled without output back-pressure")
  `GTLM_ASSERT_NOW(a_sat_limit, clk, rst, map.valid && map.saturated, map.map_x_mm == 32'sh7FFF_FFFF || map.map_x_mm == 32'sh8000_0000 || map.map_y_mm == 32'sh7FFF_FFFF || map.map_y_mm == 32'sh8000_0000, "saturated flag without a clipped coordinate")
  `GTLM_ASSERT_NOW(a_rst_clear, clk, rst, $past(rst), !map.valid, "map item shown straight after reset")

endmodule

bind gps_to_local_map_projection gtlm_chk u_chk (
  .clk (clk),
  .rst (rst),
  .gps (gps),
  .map (map)
);

// ===== tb/gps_to_local_map_projection_tb.sv =====
// Testbench for the GPS fix to local map projection block.
`timescale 1ns / 1ps
module gps_to_local_map_projection_tb;
  import gtlm_pkg::*;

  // Stage count of the sine/cosine iteration, as the block is built.
  localparam int STAGES = CORDIC_STAGES_DEF;
  localparam int DRAIN_CYCLES = 160;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;  // no register here

  localparam longint K_START  = 64'sd652032874;    // CORDIC start, Q30
  localparam longint unsigned ELL_Q30  = 64'd1080978303;  // (a/b)^2
  localparam longint unsigned SEMI_MM  = 64'd6378137000;  // a in mm
  localparam longint unsigned DEG7_RAD = 64'd2012227627;  // pi/1.8e9, Q60
  localparam longint unsigned HALF_TURN = 64'd1800000000;
  localparam longint unsigned FULL_TURN = 64'd3600000000;

  // arctan(2^-i), one turn = 2^32
  localparam longint ARCTAN [32] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
    64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001,
    64'h00000001, 64'h00000000};

  // How a directed row is checked: typed-in expectation or the predictor.
  typedef enum logic [1:0] {
    ROW_PREDICT,    // expectation from the predictor
    ROW_NO_RESULT,  // no lock: nothing may come out
    ROW_ORIGIN      // fix exactly on the origin: (0, 0), not clipped
  } row_kind_t;

  typedef struct {
    logic               has_fix;
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    row_kind_t          kind;
  } fix_item_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               sat;
  } map_point_t;

  logic clk;
  logic rst;

  gtlm_fix_if gps_ch ();
  gtlm_map_if map_ch ();
  gtlm_cfg_if cfg_ch ();

  gps_to_local_map_projection DUT (
    .clk (clk),
    .rst (rst),
    .gps (gps_ch),
    .map (map_ch),
    .cfg (cfg_ch)
  );

  // Our copy of the three registers, updated on each accepted write.
  logic signed [30:0] org_lat;
  logic signed [31:0] org_lon;
  logic [23:0]        map_rot;

  fix_item_t  fix_q[$];       // items waiting to be offered
  fix_item_t  cur_fix;        // item on the gps channel now
  map_point_t point_q[$];     // expected map points, oldest first
  bit         fix_taken;      // set at the edge the offered item goes in
  bit         hold_req;       // asks the receiver for one long hold-off
  int         errors;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Rotation-mode CORDIC on a 32 bit binary angle; results in Q30.
  function automatic void sin_cos(input logic [31:0] ang, output longint c,
                                  output longint s);
    logic [31:0] probe;
    logic [31:0] a;
    bit          flip;
    longint      x, y, z, dx, dy;
    a     = ang;
    probe = a + 32'h4000_0000;
    flip  = probe[31];           // second or third quadrant: turn by pi
    if (flip) a = a + 32'h8000_0000;
    z = longint'($signed(a));
    x = K_START;
    y = 0;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - ARCTAN[i];
      end else begin
        x = x + dx; y = y - dy; z = z + ARCTAN[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b, rem;
    r   = 0;
    rem = v;
    b   = 64'd1 << 62;
    while (b > rem) b = b >> 2;
    while (b != 0) begin
      if (rem >= r + b) begin
        rem = rem - (r + b);
        r   = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clip32(input longint v, inout bit clipped);
    if (v > 64'sd2147483647) begin
      clipped = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clipped = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Project one fix to the rotated map frame using the current registers.
  function automatic map_point_t project_fix(input logic signed [30:0] lat_in,
                                             input logic signed [31:0] lon_in);
    map_point_t      pt;
    longint          lat, lon, mag_ang, c, s, s2, spd, spd_x, e, n, cr, sr;
    longint          xr, yr;
    longint unsigned mag, d_sum, q, rad;
    logic [127:0]    wide;
    bit              clipped;
    clipped = 1'b0;
    lat = lat_in;
    lon = lon_in;
    mag = (lat < 0) ? longint'(-lat) : longint'(lat);
    mag_ang = longint'(((mag << 32) + HALF_TURN) / FULL_TURN);
    if (lat < 0) mag_ang = -mag_ang;
    sin_cos(mag_ang[31:0], c, s);

    // earth radius on the WGS84 ellipse at this latitude
    s2    = (s * s) >>> 30;
    d_sum = longint'(c * c) + ELL_Q30 * longint'(s2);
    q     = int_sqrt(d_sum);
    if (q == 0) q = 1;
    rad   = ((SEMI_MM << 30) + q / 2) / q;
    wide  = 128'(rad) * 128'(DEG7_RAD) + (128'd1 << 35);
    spd   = longint'(wide >> 36);                 // mm per 1e-7 deg, Q24
    spd_x = (spd * c + (64'sd1 << 29)) >>> 30;    // shrunk by cos(lat)

    e = (spd_x * (lon - longint'(org_lon)) + (64'sd1 << 23)) >>> 24;
    n = (spd * (lat - longint'(org_lat)) + (64'sd1 << 23)) >>> 24;

    sin_cos({map_rot, 8'h00}, cr, sr);
    cr = (cr + 8) >>> 4;
    sr = (sr + 8) >>> 4;
    xr = (e * cr - n * sr + (64'sd1 << 25)) >>> 26;
    yr = (e * sr + n * cr + (64'sd1 << 25)) >>> 26;
    xr = clip32(xr, clipped);
    yr = clip32(yr, clipped);
    pt.x   = xr[31:0];
    pt.y   = yr[31:0];
    pt.sat = clipped;
    return pt;
  endfunction

  // ---------------------------------------------------------------------
  // Monitors
  // ---------------------------------------------------------------------

  // Register writes reach our copy at the edge they are accepted.
  always @(posedge clk) begin
    if (rst) begin
      org_lat <= '0;
      org_lon <= '0;
      map_rot <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        REG_ORIGIN_LAT: org_lat <= cfg_ch.data[30:0];
        REG_ORIGIN_LON: org_lon <= cfg_ch.data;
        REG_MAP_ROT:    map_rot <= cfg_ch.data[23:0];
        default: ;    // out of range: ignored
      endcase
    end
  end

  // Accepted fix: work out what should come out of the far end.
  always @(posedge clk) begin
    map_point_t pt;
    if (!rst && gps_ch.valid && gps_ch.ready) begin
      fix_taken = 1'b1;
      case (cur_fix.kind)
        ROW_NO_RESULT: ;
        ROW_ORIGIN: begin
          pt.x = '0; pt.y = '0; pt.sat = 1'b0;
          point_q.push_back(pt);
        end
        default: begin
          if (cur_fix.has_fix) point_q.push_back(project_fix(cur_fix.lat, cur_fix.lon));
        end
      endcase
    end
  end

  // Accepted map point: compare against the oldest expectation.
  always @(posedge clk) begin
    map_point_t want;
    if (!rst && map_ch.valid && map_ch.ready) begin
      if (point_q.size() == 0) begin
        $display("%0t: map point with nothing expected: x %0d y %0d sat %0b",
                 $realtime, map_ch.map_x_mm, map_ch.map_y_mm, map_ch.saturated);
        errors++;
      end else begin
        want = point_q.pop_front();
        if (map_ch.map_x_mm !== want.x) begin
          $display("%0t: map_x_mm expected %0d got %0d", $realtime, want.x,
                   map_ch.map_x_mm);
          errors++;
        end
        if (map_ch.map_y_mm !== want.y) begin
          $display("%0t: map_y_mm expected %0d got %0d", $realtime, want.y,
                   map_ch.map_y_mm);
          errors++;
        end
        if (map_ch.saturated !== want.sat) begin
          $display("%0t: saturated expected %0b got %0b", $realtime, want.sat,
                   map_ch.saturated);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Drivers (change on the falling edge)
  // ---------------------------------------------------------------------

  // Sender: bursts of random length, random gaps between them.
  initial begin
    int burst_left;
    int gap_left;
    gps_ch.valid        = 1'b0;
    gps_ch.has_fix      = 1'b0;
    gps_ch.latitude_in  = '0;
    gps_ch.longitude_in = '0;
    cur_fix   = '{1'b0, '0, '0, ROW_PREDICT};
    fix_taken = 1'b0;
    burst_left = 1;
    gap_left   = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        gps_ch.valid <= 1'b0;
      end else if (gps_ch.valid && !fix_taken) begin
        // item still on offer: hold it
      end else begin
        fix_taken = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
          gps_ch.valid <= 1'b0;
        end else if (fix_q.size() > 0) begin
          cur_fix = fix_q.pop_front();
          gps_ch.valid        <= 1'b1;
          gps_ch.has_fix      <= cur_fix.has_fix;
          gps_ch.latitude_in  <= cur_fix.lat;
          gps_ch.longitude_in <= cur_fix.lon;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            // about a third of bursts run straight into the next one
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
          end
        end else begin
          gps_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall pattern is one of four modes, picked at random; one long hold on request.
  initial begin
    int hold_left;
    int mode;
    int tick;
    map_ch.ready = 1'b0;
    hold_left = 0;
    mode = 0;
    tick = 0;
    hold_req = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;   // well past the pipeline depth, so gps.ready drops
      end
      if (tick % 64 == 0) mode = $urandom_range(0, 3);
      tick++;
      if (hold_left > 0) begin
        hold_left--;
        map_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       map_ch.ready <= 1'b1;
          1:       map_ch.ready <= ($urandom_range(0, 3) != 0);
          2:       map_ch.ready <= 1'($urandom_range(0, 1));
          default: map_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // One register write; returns on the falling edge after it was taken.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_map(input longint lat, input longint lon, input longint rot);
    // bit 31 of the latitude word is unused; fill it at random
    write_reg(REG_ORIGIN_LAT, {1'($urandom_range(0, 1)), 31'(lat)});
    write_reg(REG_ORIGIN_LON, 32'(lon));
    write_reg(REG_MAP_ROT, {8'($urandom), 24'(rot)});
  endtask

  // Block idle: nothing queued or offered, every point back, pipe flushed.
  task automatic wait_idle();
    do @(posedge clk);
    while (fix_q.size() != 0 || gps_ch.valid || point_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_fix(input logic fix, input longint lat, input longint lon,
                           input row_kind_t kind);
    fix_item_t it;
    it.has_fix = fix;
    it.lat     = 31'(lat);
    it.lon     = 32'(lon);
    it.kind    = kind;
    fix_q.push_back(it);
  endtask

  // Random fixes: mostly near the origin, some anywhere, some on raw bits.
  task automatic queue_random(input int count);
    int     sent;
    int     pick;
    logic   fix;
    longint lat, lon;
    sent = 0;
    while (sent < count) begin
      fix  = ($urandom_range(0, 7) != 0);
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        lat = longint'(org_lat) + $signed($urandom_range(0, 4000000)) - 2000000;
        lon = longint'(org_lon) + $signed($urandom_range(0, 4000000)) - 2000000;
        if (lat > 1073741823) lat = 1073741823;
        if (lat < -1073741824) lat = -1073741824;
      end else if (pick < 8) begin
        lat = $signed($urandom_range(0, 1800000000)) - 900000000;
        lon = longint'($urandom_range(0, 3600000000)) - 1800000000;
      end else begin
        lat = longint'($signed(31'($urandom)));
        lon = longint'($signed($urandom));
      end
      queue_fix(fix, lat, lon, ROW_PREDICT);
      if (fix) sent++;   // no-lock items do not count
    end
  endtask

  // ---------------------------------------------------------------------
  // Directed table, checked with the registers at reset
  // ---------------------------------------------------------------------
  typedef struct {
    logic      fix;
    longint    lat;
    longint    lon;
    row_kind_t kind;
  } row_t;

  localparam int NROWS = 18;
  row_t rows [NROWS] = '{
    '{1'b0, 0, 0, ROW_NO_RESULT},                        // no lock
    '{1'b1, 0, 0, ROW_ORIGIN},                           // on the origin
    '{1'b0, -1073741824, -2147483648, ROW_NO_RESULT},    // no lock, extreme payload
    '{1'b1, 900000000, 0, ROW_PREDICT},                  // north pole
    '{1'b1, -900000000, 0, ROW_PREDICT},                 // south pole
    '{1'b1, 1073741823, 12345, ROW_PREDICT},             // beyond 90 deg, cos < 0
    '{1'b1, -1073741824, -12345, ROW_PREDICT},           // beyond -90 deg
    '{1'b1, 0, 1800000000, ROW_PREDICT},                 // +180 deg, clips
    '{1'b1, 0, -1800000000, ROW_PREDICT},                // -180 deg, clips
    '{1'b1, 0, 2147483647, ROW_PREDICT},                 // field top
    '{1'b1, 0, -2147483648, ROW_PREDICT},                // field bottom
    '{1'b1, 1, -1, ROW_PREDICT},
    '{1'b1, -1, 1, ROW_PREDICT},
    '{1'b1, 899999999, 1799999999, ROW_PREDICT},
    '{1'b1, 1800000, 1800000, ROW_PREDICT},
    '{1'b1, -450000000, 900000000, ROW_PREDICT},
    '{1'b1, 1073741823, 2147483647, ROW_PREDICT},
    '{1'b1, -1073741824, -2147483648, ROW_PREDICT}
  };

  // ---------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------
  initial begin
    errors = 0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_ORIGIN_LAT;
    cfg_ch.data  = '0;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // write to a register that does not exist must change nothing
    write_reg(REG_SPARE, $urandom);
    foreach (rows[i]) queue_fix(rows[i].fix, rows[i].lat, rows[i].lon, rows[i].kind);
    wait_idle();

    // origin at the extremes, rotation at both ends of its range
    set_map(900000000, 1800000000, 24'hFFFFFF);
    queue_fix(1'b1, 900000000, 1800000000, ROW_ORIGIN);   // fix on the origin
    queue_random(300);
    wait_idle();

    set_map(-900000000, -1800000000, 0);
    hold_req = 1'b1;   // long back-pressure while the sender keeps going
    queue_random(400);
    wait_idle();

    // quarter and half turns, then several random settings
    set_map($urandom_range(0, 1800000000) - 900000000,
            longint'($urandom_range(0, 3600000000)) - 1800000000, 24'h400000);
    queue_random(250);
    wait_idle();

    set_map(0, 0, 24'h800000);
    queue_random(250);
    wait_idle();

    repeat (3) begin
      set_map($urandom_range(0, 1800000000) - 900000000,
              longint'($urandom_range(0, 3600000000)) - 1800000000,
              $urandom_range(0, 24'hFFFFFF));
      // field-wide origin bits too, now and then
      if ($urandom_range(0, 1)) write_reg(REG_ORIGIN_LAT, $urandom);
      queue_random(270);
      wait_idle();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
